FILE: rtl/core/scpc_pkg.sv
`default_nettype none

package scpc_pkg;

    // field widths
    localparam int COEF_W   = 6;
    localparam int CNT_W    = 8;
    localparam int TALLY_W  = 40;
    localparam int WEIGHT_W = 11;
    localparam int MASK_W   = 64;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W   = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 1'b1;

    // reset values
    localparam logic [COEF_W-1:0] PRIME_RESET  = 6'd5;
    localparam logic [COEF_W-1:0] PRIME_MIN    = 6'd5;
    localparam logic [MASK_W-1:0] MASK_RESET   = 64'd18;
    localparam logic [CNT_W-1:0]  LOWEST_RESET = 8'd11;
    localparam int MAX_PRIME_DEF = 64;

    // small constant factors of the derivative and the square test
    localparam logic [COEF_W-1:0] K_ONE   = 6'd1;
    localparam logic [COEF_W-1:0] K_TWO   = 6'd2;
    localparam logic [COEF_W-1:0] K_THREE = 6'd3;
    localparam logic [COEF_W-1:0] K_FOUR  = 6'd4;
    localparam logic [COEF_W-1:0] K_SIX   = 6'd6;

    typedef struct packed {
        logic [COEF_W-1:0] f4;
        logic [COEF_W-1:0] f3;
        logic [COEF_W-1:0] f2;
        logic [COEF_W-1:0] f1;
        logic [COEF_W-1:0] f0;
    } coef_t;

    // saturating tally add
    function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] a,
                                                   input logic [WEIGHT_W-1:0] b);
        logic [TALLY_W:0] s;
        s = {1'b0, a} + {{(TALLY_W+1-WEIGHT_W){1'b0}}, b};
        return s[TALLY_W] ? {TALLY_W{1'b1}} : s[TALLY_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scpc_front.sv
`default_nettype none

module scpc_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [scpc_pkg::COEF_W-1:0]  coeff_x4,
    input  wire  [scpc_pkg::COEF_W-1:0]  coeff_x3,
    input  wire  [scpc_pkg::COEF_W-1:0]  coeff_x2,
    input  wire  [scpc_pkg::COEF_W-1:0]  coeff_x1,
    input  wire  [scpc_pkg::COEF_W-1:0]  coeff_x0,
    input  wire  [scpc_pkg::COEF_W-1:0]  p,
    output logic                         q_valid,
    output scpc_pkg::coef_t              q_item,
    input  wire                          q_pop
);

    // reduce a 6-bit value mod p by four conditional subtracts
    function automatic logic [scpc_pkg::COEF_W-1:0] mod_p(input logic [5:0] v,
                                                          input logic [5:0] m);
        logic [8:0] r;
        logic [8:0] sh;
        r = {3'b0, v};
        for (int k = 3; k >= 0; k--)
        begin
            sh = {3'b0, m} << k;
            if (r >= sh)
            begin
                r = r - sh;
            end
        end
        return r[5:0];
    endfunction

    scpc_pkg::coef_t red_item;
    scpc_pkg::coef_t fifo_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;

    // coefficient reduction on entry
    always_comb
    begin
        red_item.f4 = mod_p(coeff_x4, p);
        red_item.f3 = mod_p(coeff_x3, p);
        red_item.f2 = mod_p(coeff_x2, p);
        red_item.f1 = mod_p(coeff_x1, p);
        red_item.f0 = mod_p(coeff_x0, p);
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    // two-entry queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= red_item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/scpc_mulred.sv
`default_nettype none

module scpc_mulred (
    input  wire                          clk,
    input  wire  [scpc_pkg::COEF_W-1:0]  a,
    input  wire  [scpc_pkg::COEF_W-1:0]  b,
    input  wire  [scpc_pkg::COEF_W-1:0]  c,
    input  wire  [scpc_pkg::COEF_W-1:0]  p,
    output logic [scpc_pkg::COEF_W-1:0]  rem
);

    logic [scpc_pkg::PROD_W-1:0] prod_reg;
    logic [scpc_pkg::PROD_W-1:0] v;
    logic [scpc_pkg::PROD_W-1:0] sh;

    // multiply-add stage
    always_ff @(posedge clk)
    begin
        prod_reg <= ({6'b0, a} * {6'b0, b}) + {6'b0, c};
    end

    // reduction stage: value stays below 64p, six conditional subtracts
    always_comb
    begin
        v = prod_reg;
        for (int k = 5; k >= 0; k--)
        begin
            sh = {6'b0, p} << k;
            if (v >= sh)
            begin
                v = v - sh;
            end
        end
        rem = v[scpc_pkg::COEF_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/core/scpc_back.sv
`default_nettype none

module scpc_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [scpc_pkg::COEF_W-1:0]  p,
    input  wire  [scpc_pkg::MASK_W-1:0]  mask,
    input  wire                          lowest_load,
    input  wire  [scpc_pkg::CNT_W-1:0]   lowest_init,
    input  wire                          q_valid,
    input  scpc_pkg::coef_t              q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [scpc_pkg::CNT_W-1:0]   smooth_points,
    output logic [scpc_pkg::CNT_W-1:0]   twist_points,
    output logic                         curve_empty,
    output logic                         twist_empty,
    output logic [scpc_pkg::CNT_W-1:0]   least_count,
    output logic [scpc_pkg::TALLY_W-1:0] empty_orbits,
    output logic [scpc_pkg::TALLY_W-1:0] empty_weighted,
    output logic [scpc_pkg::TALLY_W-1:0] twist_orbits,
    output logic [scpc_pkg::TALLY_W-1:0] twist_weighted
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [2:0] LAST_SETUP = 3'd4;
    localparam logic [2:0] LAST_EVAL  = 3'd5;

    logic [1:0]                  state_reg;
    logic                        phase_reg;
    logic [2:0]                  step_reg;
    logic [5:0]                  x_reg;
    scpc_pkg::coef_t             coef_reg;
    logic [5:0]                  c4_reg, c3_reg, c2_reg, c6_reg;
    logic [5:0]                  h0_reg, h1_reg, hp_reg;
    logic [5:0]                  sqa_reg, sqb_reg, sqc_reg;
    logic [5:0]                  f_acc_reg, d_acc_reg;
    logic [scpc_pkg::CNT_W-1:0]  cnt_reg, ucnt_reg;
    logic [scpc_pkg::CNT_W-1:0]  lowest_reg;
    logic [scpc_pkg::TALLY_W-1:0] eo_reg, ew_reg, to_reg, tw_reg;
    logic [scpc_pkg::WEIGHT_W-1:0] pair_weight_reg;
    logic                        out_valid_reg;

    logic [5:0]  half;
    logic [6:0]  p_plus;
    logic [5:0]  a_a, a_b, a_c, b_a, b_b, b_c;
    logic [5:0]  rem_a, rem_b;
    logic        commit;
    logic        square;
    logic        cur_empty, tw_empty;
    logic [scpc_pkg::CNT_W-1:0] lowest_next;
    logic [scpc_pkg::WEIGHT_W-1:0] weight;
    logic [scpc_pkg::CNT_W-1:0] cnt_next, ucnt_next;
    logic [12:0] pw_prod;

    assign p_plus = {1'b0, p} + 7'd1;
    assign half   = p_plus[6:1];
    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // two multiply-reduce lanes
    scpc_mulred u_lane_a (.clk(clk), .a(a_a), .b(a_b), .c(a_c), .p(p), .rem(rem_a));
    scpc_mulred u_lane_b (.clk(clk), .a(b_a), .b(b_b), .c(b_c), .p(p), .rem(rem_b));

    // operand selection per step
    always_comb
    begin
        a_a = '0; a_b = '0; a_c = '0;
        b_a = '0; b_b = '0; b_c = '0;
        if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                3'd0:
                begin
                    a_a = coef_reg.f4; a_b = scpc_pkg::K_FOUR;
                    b_a = coef_reg.f3; b_b = scpc_pkg::K_THREE;
                end
                3'd1:
                begin
                    a_a = coef_reg.f2; a_b = scpc_pkg::K_TWO;
                    b_a = coef_reg.f3; b_b = half;
                end
                3'd2:
                begin
                    a_a = coef_reg.f4;      a_b = half;
                    b_a = scpc_pkg::K_ONE;  b_b = scpc_pkg::K_SIX;
                end
                3'd3:
                begin
                    a_a = h1_reg; a_b = h1_reg;
                    b_a = h0_reg; b_b = h1_reg;
                end
                3'd4:
                begin
                    a_a = h0_reg; a_b = h0_reg;
                    b_a = hp_reg; b_b = scpc_pkg::K_TWO;
                end
                default:
                begin
                    a_a = '0;
                end
            endcase
        end
        else if (state_reg == ST_EVAL)
        begin
            a_a = f_acc_reg; a_b = x_reg;
            b_a = d_acc_reg; b_b = x_reg;
            case (step_reg)
                3'd0:
                begin
                    a_c = '0;          b_c = c6_reg;
                end
                3'd1:
                begin
                    a_c = coef_reg.f4; b_c = '0;
                end
                3'd2:
                begin
                    a_c = coef_reg.f3; b_c = c4_reg;
                end
                3'd3:
                begin
                    a_c = coef_reg.f2; b_c = c3_reg;
                end
                3'd4:
                begin
                    a_c = coef_reg.f1; b_c = c2_reg;
                end
                3'd5:
                begin
                    a_c = coef_reg.f0; b_c = coef_reg.f1;
                end
                default:
                begin
                    a_c = '0;
                end
            endcase
        end
    end

    // per-x point tally from f(x) and f'(x)
    always_comb
    begin
        cnt_next  = cnt_reg;
        ucnt_next = ucnt_reg;
        if (rem_a == 6'd0)
        begin
            if (rem_b != 6'd0)
            begin
                cnt_next  = cnt_reg + 8'd1;
                ucnt_next = ucnt_reg + 8'd1;
            end
        end
        else if (mask[rem_a])
        begin
            cnt_next = cnt_reg + 8'd2;
        end
        else
        begin
            ucnt_next = ucnt_reg + 8'd2;
        end
    end

    // end-of-item classification
    always_comb
    begin
        square    = (coef_reg.f2 == sqa_reg) && (coef_reg.f1 == sqc_reg) &&
                    (coef_reg.f0 == sqb_reg);
        cur_empty = (cnt_reg == 8'd0);
        tw_empty  = (ucnt_reg == 8'd0) && !square;
        lowest_next = (cnt_reg < lowest_reg) ? cnt_reg : lowest_reg;
        weight    = (coef_reg.f4 == 6'd0) ? {5'b0, p} : pair_weight_reg;
    end

    // orbit weight p(p-1)/2
    assign pw_prod = 13'({7'b0, p} * {7'b0, p - 6'd1});

    always_ff @(posedge clk)
    begin
        pair_weight_reg <= pw_prod[11:1];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            step_reg  <= 3'd0;
            x_reg     <= 6'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_SETUP;
                        phase_reg <= 1'b0;
                        step_reg  <= 3'd0;
                    end
                end
                ST_SETUP:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        if (step_reg == LAST_SETUP)
                        begin
                            state_reg <= ST_EVAL;
                            step_reg  <= 3'd0;
                            x_reg     <= 6'd0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 3'd1;
                        end
                    end
                end
                ST_EVAL:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        if (step_reg == LAST_EVAL)
                        begin
                            step_reg <= 3'd0;
                            x_reg    <= x_reg + 6'd1;
                            if (x_reg == p - 6'd1)
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 3'd1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers of the current item
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            coef_reg <= q_item;
        end
        if ((state_reg == ST_SETUP) && phase_reg)
        begin
            case (step_reg)
                3'd0:
                begin
                    c4_reg <= rem_a; c3_reg <= rem_b;
                end
                3'd1:
                begin
                    c2_reg <= rem_a; h0_reg <= rem_b;
                end
                3'd2:
                begin
                    h1_reg <= rem_a; c6_reg <= rem_b;
                end
                3'd3:
                begin
                    sqa_reg <= rem_a; hp_reg <= rem_b;
                end
                default:
                begin
                    sqb_reg <= rem_a; sqc_reg <= rem_b;
                end
            endcase
            f_acc_reg <= scpc_pkg::K_ONE;
            d_acc_reg <= '0;
        end
        if ((state_reg == ST_EVAL) && phase_reg)
        begin
            if (step_reg == LAST_EVAL)
            begin
                f_acc_reg <= scpc_pkg::K_ONE;
                d_acc_reg <= '0;
            end
            else
            begin
                f_acc_reg <= rem_a;
                d_acc_reg <= rem_b;
            end
        end
    end

    // running counts, tallies and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ucnt_reg      <= '0;
            lowest_reg    <= scpc_pkg::LOWEST_RESET;
            eo_reg        <= '0;
            ew_reg        <= '0;
            to_reg        <= '0;
            tw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cnt_reg  <= '0;
                ucnt_reg <= '0;
            end
            else if ((state_reg == ST_EVAL) && phase_reg && (step_reg == LAST_EVAL))
            begin
                cnt_reg  <= cnt_next;
                ucnt_reg <= ucnt_next;
            end
            if (lowest_load)
            begin
                lowest_reg <= lowest_init;
            end
            else if (commit)
            begin
                lowest_reg <= lowest_next;
            end
            if (commit)
            begin
                if (cur_empty)
                begin
                    eo_reg <= scpc_pkg::sat_add(eo_reg, 11'd1);
                    ew_reg <= scpc_pkg::sat_add(ew_reg, weight);
                end
                if (tw_empty)
                begin
                    to_reg <= scpc_pkg::sat_add(to_reg, 11'd1);
                    tw_reg <= scpc_pkg::sat_add(tw_reg, weight);
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            smooth_points  <= cnt_reg;
            twist_points   <= ucnt_reg;
            curve_empty    <= cur_empty;
            twist_empty    <= tw_empty;
            least_count    <= lowest_next;
            empty_orbits   <= cur_empty ? scpc_pkg::sat_add(eo_reg, 11'd1) : eo_reg;
            empty_weighted <= cur_empty ? scpc_pkg::sat_add(ew_reg, weight) : ew_reg;
            twist_orbits   <= tw_empty ? scpc_pkg::sat_add(to_reg, 11'd1) : to_reg;
            twist_weighted <= tw_empty ? scpc_pkg::sat_add(tw_reg, weight) : tw_reg;
        end
    end

    // x stays inside the field while evaluating
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (x_reg < p))
        else $error("x out of range");

    // each x adds at most two points over both curves
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |->
        (({1'b0, cnt_reg} + {1'b0, ucnt_reg}) <= {2'b0, x_reg, 1'b0}))
        else $error("point count exceeds bound");

    // running minimum never above its initial value
    a_lowest: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_reg <= {1'b0, p, 1'b1})
        else $error("lowest count above 2p+1");

endmodule

`default_nettype wire

FILE: rtl/core/sextic_curve_point_counter.sv
`default_nettype none
// sextic curve point counter over GF(p)
// input channel: in_valid/in_stall with the five coefficients of a monic sextic;
// a transaction is taken when in_valid is high and in_stall low. coefficients
// are reduced mod p on entry and held in a two-entry queue.
// output channel: out_valid/out_stall with point counts, emptiness flags, the
// running minimum and four saturating tallies; one result per input.
// configuration: cfg_wr_en, cfg_index, cfg_data; index 0 is the modulus (also
// reloads the running minimum to 2p+1), index 1 the residue mask. write only
// while idle.
// schedule: each multiply-reduce step runs on a pair of lanes; each item needs
// 5 setup steps and 6 Horner steps per x, so its work is set by the Horner
// loop over x. the queue takes new items while one is evaluated.
// stall: a held result stays in the output register; the evaluator finishes
// its current item and waits, and the queue fills before in_stall rises.
// reset: modulus 5, mask 18, minimum 11, tallies zero, nothing queued.
module sextic_curve_point_counter #(
    parameter int MAX_PRIME = scpc_pkg::MAX_PRIME_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire  [scpc_pkg::COEF_W-1:0]     coeff_x4,
    input  wire  [scpc_pkg::COEF_W-1:0]     coeff_x3,
    input  wire  [scpc_pkg::COEF_W-1:0]     coeff_x2,
    input  wire  [scpc_pkg::COEF_W-1:0]     coeff_x1,
    input  wire  [scpc_pkg::COEF_W-1:0]     coeff_x0,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [scpc_pkg::CNT_W-1:0]      smooth_points,
    output logic [scpc_pkg::CNT_W-1:0]      twist_points,
    output logic                            curve_empty,
    output logic                            twist_empty,
    output logic [scpc_pkg::CNT_W-1:0]      least_count,
    output logic [scpc_pkg::TALLY_W-1:0]    empty_orbits,
    output logic [scpc_pkg::TALLY_W-1:0]    empty_weighted,
    output logic [scpc_pkg::TALLY_W-1:0]    twist_orbits,
    output logic [scpc_pkg::TALLY_W-1:0]    twist_weighted,
    input  wire                             cfg_wr_en,
    input  wire  [scpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [scpc_pkg::MASK_W-1:0]     cfg_data
);

    localparam logic [scpc_pkg::COEF_W-1:0] PMAX =
        (MAX_PRIME > 63) ? 6'd63 : 6'(MAX_PRIME);

    logic [scpc_pkg::COEF_W-1:0] prime_reg;
    logic [scpc_pkg::COEF_W-1:0] prime_next;
    logic [scpc_pkg::MASK_W-1:0] mask_reg;
    logic                        prime_wr;
    logic                        q_valid;
    logic                        q_pop;
    scpc_pkg::coef_t             q_item;

    // working modulus clamp
    always_comb
    begin
        prime_next = cfg_data[scpc_pkg::COEF_W-1:0];
        if (prime_next < scpc_pkg::PRIME_MIN)
        begin
            prime_next = scpc_pkg::PRIME_MIN;
        end
        else if (prime_next > PMAX)
        begin
            prime_next = PMAX;
        end
    end

    assign prime_wr = cfg_wr_en && (cfg_index == scpc_pkg::REG_PRIME);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= scpc_pkg::PRIME_RESET;
            mask_reg  <= scpc_pkg::MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                scpc_pkg::REG_PRIME: prime_reg <= prime_next;
                scpc_pkg::REG_MASK:  mask_reg  <= cfg_data;
                default:             mask_reg  <= mask_reg;
            endcase
        end
    end

    scpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .coeff_x4 (coeff_x4),
        .coeff_x3 (coeff_x3),
        .coeff_x2 (coeff_x2),
        .coeff_x1 (coeff_x1),
        .coeff_x0 (coeff_x0),
        .p        (prime_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    scpc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .p              (prime_reg),
        .mask           (mask_reg),
        .lowest_load    (prime_wr),
        .lowest_init    ({1'b0, prime_next, 1'b1}),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smooth_points  (smooth_points),
        .twist_points   (twist_points),
        .curve_empty    (curve_empty),
        .twist_empty    (twist_empty),
        .least_count    (least_count),
        .empty_orbits   (empty_orbits),
        .empty_weighted (empty_weighted),
        .twist_orbits   (twist_orbits),
        .twist_weighted (twist_weighted)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int HANG_LIMIT = 50000;
    localparam int HOLD_CYCLES = 4000;

    typedef struct {
        logic [scpc_pkg::CNT_W-1:0]   smooth;
        logic [scpc_pkg::CNT_W-1:0]   twist;
        logic                         c_empty;
        logic                         t_empty;
        logic [scpc_pkg::CNT_W-1:0]   least;
        logic [scpc_pkg::TALLY_W-1:0] e_orb;
        logic [scpc_pkg::TALLY_W-1:0] e_wgt;
        logic [scpc_pkg::TALLY_W-1:0] t_orb;
        logic [scpc_pkg::TALLY_W-1:0] t_wgt;
    } count_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [scpc_pkg::COEF_W-1:0] coeff_x4 = '0, coeff_x3 = '0, coeff_x2 = '0;
    logic [scpc_pkg::COEF_W-1:0] coeff_x1 = '0, coeff_x0 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [scpc_pkg::CNT_W-1:0] smooth_points, twist_points, least_count;
    logic curve_empty, twist_empty;
    logic [scpc_pkg::TALLY_W-1:0] empty_orbits, empty_weighted, twist_orbits, twist_weighted;
    logic cfg_wr_en = 1'b0;
    logic [scpc_pkg::CFG_IDX_W-1:0] cfg_index = scpc_pkg::REG_PRIME;
    logic [scpc_pkg::MASK_W-1:0] cfg_data = '0;

    // predictor state
    logic [scpc_pkg::COEF_W-1:0]  mdl_prime;
    logic [scpc_pkg::MASK_W-1:0]  mdl_mask;
    logic [scpc_pkg::CNT_W-1:0]   mdl_lowest;
    logic [scpc_pkg::TALLY_W-1:0] mdl_e_orb, mdl_e_wgt, mdl_t_orb, mdl_t_wgt;

    count_res_t pending_counts[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_request = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    sextic_curve_point_counter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .coeff_x4(coeff_x4), .coeff_x3(coeff_x3), .coeff_x2(coeff_x2),
        .coeff_x1(coeff_x1), .coeff_x0(coeff_x0),
        .out_valid(out_valid), .out_stall(out_stall),
        .smooth_points(smooth_points), .twist_points(twist_points),
        .curve_empty(curve_empty), .twist_empty(twist_empty),
        .least_count(least_count),
        .empty_orbits(empty_orbits), .empty_weighted(empty_weighted),
        .twist_orbits(twist_orbits), .twist_weighted(twist_weighted),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned field_size();
        int unsigned p;
        p = mdl_prime;
        if (p < 5) p = 5;
        return p;
    endfunction

    function automatic logic [scpc_pkg::TALLY_W-1:0] tally_add(
        logic [scpc_pkg::TALLY_W-1:0] a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'hFF_FFFF_FFFF) ? {scpc_pkg::TALLY_W{1'b1}} : s[scpc_pkg::TALLY_W-1:0];
    endfunction

    // count points on the curve and its twist, then update the running tallies
    function automatic count_res_t count_points(
        logic [scpc_pkg::COEF_W-1:0] c4, logic [scpc_pkg::COEF_W-1:0] c3,
        logic [scpc_pkg::COEF_W-1:0] c2, logic [scpc_pkg::COEF_W-1:0] c1,
        logic [scpc_pkg::COEF_W-1:0] c0);
        count_res_t r;
        int unsigned p, half, a4, a3, a2, a1, a0, x, x2, x3, x4, x5, x6, fv, dv, chi;
        int unsigned pts, tw, h0, h1, wgt;
        bit square;
        p = field_size();
        half = (p + 1) / 2;
        a4 = c4 % p; a3 = c3 % p; a2 = c2 % p; a1 = c1 % p; a0 = c0 % p;
        pts = 0; tw = 0;
        for (x = 0; x < p; x++)
        begin
            x2 = (x * x) % p; x3 = (x2 * x) % p; x4 = (x3 * x) % p;
            x5 = (x4 * x) % p; x6 = (x5 * x) % p;
            fv = (x6 + a4 * x4 + a3 * x3 + a2 * x2 + a1 * x + a0) % p;
            dv = (6 * x5 + 4 * a4 * x3 + 3 * a3 * x2 + 2 * a2 * x + a1) % p;
            if (fv == 0) chi = 1;
            else chi = mdl_mask[fv] ? 2 : 0;
            // a singular root adds nothing
            if (chi != 1 || dv != 0)
            begin
                pts += chi;
                tw += 2 - chi;
            end
        end
        h0 = (half * a3) % p;
        h1 = (half * a4) % p;
        square = (a2 == (h1 * h1) % p) && (a1 == (2 * h0 * h1) % p) && (a0 == (h0 * h0) % p);
        wgt = (a4 == 0) ? p : p * (p - 1) / 2;
        r.smooth = pts[scpc_pkg::CNT_W-1:0];
        r.twist = tw[scpc_pkg::CNT_W-1:0];
        r.c_empty = (pts == 0);
        r.t_empty = (tw == 0) && !square;
        if (pts < mdl_lowest) mdl_lowest = pts[scpc_pkg::CNT_W-1:0];
        if (r.c_empty)
        begin
            mdl_e_orb = tally_add(mdl_e_orb, 1);
            mdl_e_wgt = tally_add(mdl_e_wgt, wgt);
        end
        if (r.t_empty)
        begin
            mdl_t_orb = tally_add(mdl_t_orb, 1);
            mdl_t_wgt = tally_add(mdl_t_wgt, wgt);
        end
        r.least = mdl_lowest;
        r.e_orb = mdl_e_orb; r.e_wgt = mdl_e_wgt;
        r.t_orb = mdl_t_orb; r.t_wgt = mdl_t_wgt;
        return r;
    endfunction

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // squares mod p, bit (k*k mod p) set for each nonzero k below p
    function automatic logic [scpc_pkg::MASK_W-1:0] square_mask(int unsigned p);
        logic [scpc_pkg::MASK_W-1:0] m;
        m = '0;
        for (int unsigned k = 1; k < p; k++) m[(k * k) % p] = 1'b1;
        return m;
    endfunction

    // receiver side: random stall stretches, or a long hold when requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_request <= hold_request - 1;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall <= 1'b1;
            stall_left <= pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [scpc_pkg::TALLY_W-1:0] exp_v,
                               logic [scpc_pkg::TALLY_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d got %0d at %0t", name, exp_v, act_v, $realtime);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        count_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                e = pending_counts.pop_front();
                check_field("smooth_points", e.smooth, smooth_points);
                check_field("twist_points", e.twist, twist_points);
                check_field("curve_empty", e.c_empty, curve_empty);
                check_field("twist_empty", e.t_empty, twist_empty);
                check_field("least_count", e.least, least_count);
                check_field("empty_orbits", e.e_orb, empty_orbits);
                check_field("empty_weighted", e.e_wgt, empty_weighted);
                check_field("twist_orbits", e.t_orb, twist_orbits);
                check_field("twist_weighted", e.t_wgt, twist_weighted);
            end
        end
    end

    // hang watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // coefficients keep their low six bits, as the input fields do
    task automatic send_curve(int unsigned c4, int unsigned c3, int unsigned c2,
                              int unsigned c1, int unsigned c0);
        int g;
        in_valid <= 1'b1;
        coeff_x4 <= c4[scpc_pkg::COEF_W-1:0];
        coeff_x3 <= c3[scpc_pkg::COEF_W-1:0];
        coeff_x2 <= c2[scpc_pkg::COEF_W-1:0];
        coeff_x1 <= c1[scpc_pkg::COEF_W-1:0];
        coeff_x0 <= c0[scpc_pkg::COEF_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_counts.push_back(count_points(c4[scpc_pkg::COEF_W-1:0],
                                              c3[scpc_pkg::COEF_W-1:0],
                                              c2[scpc_pkg::COEF_W-1:0],
                                              c1[scpc_pkg::COEF_W-1:0],
                                              c0[scpc_pkg::COEF_W-1:0]));
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random();
        send_curve($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    // f = (x^3 + h1 x + h0)^2 with random h
    task automatic send_square();
        int unsigned p, h0, h1;
        p = field_size();
        h0 = $urandom_range(0, p - 1);
        h1 = $urandom_range(0, p - 1);
        send_curve((2 * h1) % p, (2 * h0) % p, (h1 * h1) % p, (2 * h0 * h1) % p, (h0 * h0) % p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [scpc_pkg::CFG_IDX_W-1:0] idx,
                             logic [scpc_pkg::MASK_W-1:0] val);
        int unsigned lw;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == scpc_pkg::REG_PRIME)
        begin
            mdl_prime = val[scpc_pkg::COEF_W-1:0];
            lw = 2 * field_size() + 1;
            mdl_lowest = lw[scpc_pkg::CNT_W-1:0];
        end
        else
        begin
            mdl_mask = val;
        end
    endtask

    task automatic set_field(logic [scpc_pkg::COEF_W-1:0] p);
        drain();
        write_reg(scpc_pkg::REG_PRIME, {58'b0, p});
        write_reg(scpc_pkg::REG_MASK, square_mask(p < 5 ? 5 : p));
    endtask

    task automatic test_reset_values();
        send_curve(0, 0, 0, 0, 0);
        send_curve(63, 63, 63, 63, 63);
        send_square();
        send_curve(1, 2, 3, 4, 5);
    endtask

    task automatic test_directed_fields();
        set_field(6'd61);
        send_curve(0, 0, 0, 0, 0);
        send_curve(63, 63, 63, 63, 63);
        send_curve(61, 0, 60, 0, 1);
        send_square();
        // modulus below range clamps to five
        set_field(6'd2);
        send_curve(0, 0, 0, 0, 0);
        send_square();
        send_curve(42, 21, 10, 5, 63);
        // odd composite modulus
        set_field(6'd63);
        send_square();
        send_curve(62, 1, 62, 1, 62);
        // residue mask extremes
        drain();
        write_reg(scpc_pkg::REG_MASK, '0);
        send_curve(0, 0, 0, 0, 3);
        send_random();
        drain();
        write_reg(scpc_pkg::REG_MASK, '1);
        send_curve(0, 0, 0, 0, 3);
        send_random();
        // arbitrary mask with a prime
        set_field(6'd7);
        drain();
        write_reg(scpc_pkg::REG_MASK, {$urandom, $urandom});
        send_random();
        send_square();
        send_curve(0, 0, 0, 0, 0);
    endtask

    task automatic test_random_sweep();
        logic [scpc_pkg::COEF_W-1:0] big_set[5] = '{59, 61, 63, 9, 3};
        logic [scpc_pkg::COEF_W-1:0] small_set[4] = '{5, 7, 11, 13};
        for (int ph = 0; ph < 8; ph++)
        begin
            if ($urandom_range(0, 3) == 0) set_field(big_set[$urandom_range(0, 4)]);
            else set_field(small_set[$urandom_range(0, 3)]);
            calm = (ph == 2);
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 9) == 0) send_square();
                else send_random();
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_back_pressure();
        set_field(6'd5);
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) send_random();
        drain();
        for (int i = 0; i < 6; i++) send_random();
        drain();
    endtask

    initial
    begin
        mdl_prime = scpc_pkg::PRIME_RESET;
        mdl_mask = scpc_pkg::MASK_RESET;
        mdl_lowest = scpc_pkg::LOWEST_RESET;
        mdl_e_orb = '0; mdl_e_wgt = '0; mdl_t_orb = '0; mdl_t_wgt = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_fields();
        test_back_pressure();
        test_random_sweep();
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
